@@ design/line_interp_two_point_assert.svh @@
// Assertion macros shared by the two-point line interpolator.
`ifndef LINE_INTERP_TWO_POINT_ASSERT_SVH
`define LINE_INTERP_TWO_POINT_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define LIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_interp_two_point: same-cycle check failed");

// Next-cycle implication, skipped while reset is high.
`define LIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_interp_two_point: next-cycle check failed");

`endif

@@ design/lip_pkg.sv @@
// Constants and register codes of the two-point line interpolator.
`default_nettype none

package lip_pkg;

   localparam int COORD_W             = 16;
   localparam int SLOPE_FRACTION_BITS = 16;
   localparam int SLOPE_W             = COORD_W + SLOPE_FRACTION_BITS;
   localparam int PROD_W              = SLOPE_W + COORD_W;
   localparam int DIV_CNT_W           = $clog2(SLOPE_W + 1);
   localparam int CSR_INDEX_W         = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_A_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_A_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_B_X = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_B_Y = 2'd3;

   localparam logic [COORD_W-1:0] POINT_A_X_RESET = 16'd0;
   localparam logic [COORD_W-1:0] POINT_A_Y_RESET = 16'd0;
   localparam logic [COORD_W-1:0] POINT_B_X_RESET = 16'd1;
   localparam logic [COORD_W-1:0] POINT_B_Y_RESET = 16'd1;

endpackage

`default_nettype wire

@@ design/line_interp_two_point.sv @@
// Two-point line interpolator: slope divider and three-stage query pipeline.
`default_nettype none

// Maps each query x onto the straight line through two programmed points A and B
// (sensor linearization). The point with the smaller x is the left point L; the
// result is Ly plus or minus bits 31:16 of slope*|x-Lx|, where the Q16 slope is
// floor(|dy|*65536/dx), kept at 32 bits. rsp_tuser flags equal x coordinates
// (result 0), a product of 2^32 or more, or a sum outside 0..65535.
// Throughput is one query per clock while the output is not stalled and the
// divider is idle. A query passes the s1, s2 and s3 registers before rsp_tvalid
// rises. A stalled output only holds the last stage, so the front keeps taking
// queries until the pipeline is full. The slope comes from a restoring divider
// that retires one quotient bit per clock: after reset and after every register
// write it loads its operands and then works out all SLOPE_W quotient bits,
// during which req_tready is low. CSR writes are always taken and belong in idle
// time, with no query in flight.
module line_interp_two_point
   import lip_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // query stream
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [15:0]            req_tdata,   // [15:0] query_x

   // result stream
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [15:0]            rsp_tdata,   // [15:0] line_y
   output      logic [0:0]             rsp_tuser,   // [0] range_error

   // register writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]     csr_data
);

`include "line_interp_two_point_assert.svh"

   // ---------------------------------------------------------------------
   // Point registers
   // ---------------------------------------------------------------------
   logic [COORD_W-1:0] point_a_x_ff, point_a_y_ff, point_b_x_ff, point_b_y_ff;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_a_x_ff <= POINT_A_X_RESET;
         point_a_y_ff <= POINT_A_Y_RESET;
         point_b_x_ff <= POINT_B_X_RESET;
         point_b_y_ff <= POINT_B_Y_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POINT_A_X: point_a_x_ff <= csr_data;
            CSR_POINT_A_Y: point_a_y_ff <= csr_data;
            CSR_POINT_B_X: point_b_x_ff <= csr_data;
            CSR_POINT_B_Y: point_b_y_ff <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Line setup: order the points, get |dy| and dx
   // ---------------------------------------------------------------------
   logic               a_is_left;
   logic [COORD_W-1:0] lx_in, ly_in, rx_in, ry_in, dx_in, dy_in;
   logic               falling_in;

   always_comb begin
      a_is_left  = !(point_a_x_ff > point_b_x_ff);   // tie keeps A on the left
      lx_in      = a_is_left ? point_a_x_ff : point_b_x_ff;
      ly_in      = a_is_left ? point_a_y_ff : point_b_y_ff;
      rx_in      = a_is_left ? point_b_x_ff : point_a_x_ff;
      ry_in      = a_is_left ? point_b_y_ff : point_a_y_ff;
      falling_in = ly_in > ry_in;
      dy_in      = falling_in ? (ly_in - ry_in) : (ry_in - ly_in);
      dx_in      = rx_in - lx_in;
   end

   logic [COORD_W-1:0] lx_ff, ly_ff, dx_ff;
   logic               falling_ff, same_x_ff;

   // ---------------------------------------------------------------------
   // Slope divider: restoring, one quotient bit per clock.
   // quot_ff starts as the numerator and fills with quotient bits from below.
   // ---------------------------------------------------------------------
   logic                 start_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [SLOPE_W-1:0]   quot_ff;
   logic [COORD_W-1:0]   rem_ff;
   logic [COORD_W:0]     trial;
   logic                 trial_fits;
   logic                 slope_ok;

   assign trial      = {rem_ff, quot_ff[SLOPE_W-1]};
   assign trial_fits = trial >= {1'b0, dx_ff};
   assign slope_ok   = !start_ff && (div_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= 1'b1;
         div_cnt_ff <= '0;
      end else begin
         // any write restarts the setup, also one that lands mid-division
         start_ff <= csr_write;
         if (start_ff) begin
            div_cnt_ff <= DIV_CNT_W'(SLOPE_W);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         lx_ff      <= lx_in;
         ly_ff      <= ly_in;
         dx_ff      <= dx_in;
         falling_ff <= falling_in;
         same_x_ff  <= (dx_in == '0);
         quot_ff    <= {dy_in, {SLOPE_FRACTION_BITS{1'b0}}};
         rem_ff     <= '0;
      end else if (div_cnt_ff != '0) begin
         rem_ff  <= trial_fits ? COORD_W'(trial - {1'b0, dx_ff}) : trial[COORD_W-1:0];
         quot_ff <= {quot_ff[SLOPE_W-2:0], trial_fits};
      end
   end

   // ---------------------------------------------------------------------
   // Query pipeline. Each stage moves when the one after it is empty or moving.
   // ---------------------------------------------------------------------
   logic s1_en, s2_en, s3_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   assign s3_en      = !s3_valid_ff || rsp_tready;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en && slope_ok;

   // stage 1: side of Lx and distance from it
   logic               s1_past_in;
   logic [COORD_W-1:0] s1_dist_in;
   logic               s1_past_ff;
   logic [COORD_W-1:0] s1_dist_ff;

   assign s1_past_in = req_tdata >= lx_ff;
   assign s1_dist_in = s1_past_in ? (req_tdata - lx_ff) : (lx_ff - req_tdata);

   // stage 2: slope times distance
   logic [PROD_W-1:0]  s2_prod_ff;
   logic               s2_past_ff;

   // stage 3: overflow check, add or subtract, output register
   logic [31:0]        prod_lo;
   logic [31:0]        inc_wide;
   logic [COORD_W-1:0] inc;
   logic               prod_ovf;
   logic               add_dir;
   logic [COORD_W:0]   sum_ext, diff_ext;
   logic [COORD_W-1:0] s3_y_in;
   logic               s3_err_in;
   logic [COORD_W-1:0] s3_y_ff;
   logic               s3_err_ff;

   always_comb begin
      prod_lo  = s2_prod_ff[31:0];
      prod_ovf = |s2_prod_ff[PROD_W-1:32];
      inc_wide = prod_lo >> SLOPE_FRACTION_BITS;
      inc      = inc_wide[COORD_W-1:0];
      add_dir  = s2_past_ff ^ falling_ff;
      sum_ext  = {1'b0, ly_ff} + {1'b0, inc};
      diff_ext = {1'b0, ly_ff} - {1'b0, inc};
      if (same_x_ff) begin
         s3_y_in   = '0;
         s3_err_in = 1'b1;
      end else if (add_dir) begin
         s3_y_in   = sum_ext[COORD_W-1:0];
         s3_err_in = prod_ovf || sum_ext[COORD_W];
      end else begin
         s3_y_in   = diff_ext[COORD_W-1:0];
         s3_err_in = prod_ovf || diff_ext[COORD_W];   // borrow: inc above Ly
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_tvalid && slope_ok;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_past_ff <= s1_past_in;
         s1_dist_ff <= s1_dist_in;
      end
      if (s2_en) begin
         s2_prod_ff <= PROD_W'(quot_ff) * PROD_W'(s1_dist_ff);
         s2_past_ff <= s1_past_ff;
      end
      if (s3_en) begin
         s3_y_ff   <= s3_y_in;
         s3_err_ff <= s3_err_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_y_ff;
   assign rsp_tuser  = s3_err_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `LIP_ASSERT_NOW(no_query_while_dividing, clock, reset,
                   (div_cnt_ff != '0) || start_ff, !req_tready)
   `LIP_ASSERT_NEXT(divider_loads_full_count, clock, reset,
                    start_ff, start_ff || (div_cnt_ff == DIV_CNT_W'(SLOPE_W)))
   `LIP_ASSERT_NEXT(stage2_moves_to_output, clock, reset,
                    s2_valid_ff && s3_en, rsp_tvalid)
   `LIP_ASSERT_NEXT(stage1_moves_to_stage2, clock, reset,
                    s1_valid_ff && s2_en, s2_valid_ff)

endmodule

`default_nettype wire
